### rtl/mbce_pkg.sv
// ----------------------------------------------------------------------------
// mbce_pkg
// Types and constants for the monochrome bitmap color expander.
// ----------------------------------------------------------------------------
`default_nettype none

package mbce_pkg;

  localparam int BYTE_W     = 8;
  localparam int COLOR_W    = 16;
  localparam int ORIGIN_W   = 10;
  localparam int STRIDE_W   = 11;
  localparam int DIM_W      = 8;
  localparam int ROW_W      = 8;
  localparam int COL_W      = 6;
  localparam int BPR_W      = 6;
  localparam int SUM_W      = 11;
  localparam int FULL_W     = 22;
  localparam int PIX_ADDR_W = 20;
  localparam int BIT_IDX_W  = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_STRIDE = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ICON_WIDTH   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ICON_HEIGHT  = 8'd7;

  localparam logic [COLOR_W-1:0]  FG_RESET     = 16'hF800;
  localparam logic [COLOR_W-1:0]  BG_RESET     = 16'h0000;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd800;
  localparam logic [DIM_W-1:0]    WIDTH_RESET  = 8'd8;
  localparam logic [DIM_W-1:0]    HEIGHT_RESET = 8'd1;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;
    logic                transparent;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [STRIDE_W-1:0] frame_stride;
    logic [DIM_W-1:0]    icon_width;
    logic [DIM_W-1:0]    icon_height;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] bits;
    logic [FULL_W-1:0] base;
    logic              last;
  } item_t;

endpackage

`default_nettype wire

### rtl/mbce_cfg.sv
// ----------------------------------------------------------------------------
// mbce_cfg
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_cfg
  import mbce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color     <= FG_RESET;
      cfg.bg_color     <= BG_RESET;
      cfg.transparent  <= 1'b1;
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.frame_stride <= STRIDE_RESET;
      cfg.icon_width   <= WIDTH_RESET;
      cfg.icon_height  <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FG_COLOR:     cfg.fg_color     <= cfg_data[COLOR_W-1:0];
        REG_BG_COLOR:     cfg.bg_color     <= cfg_data[COLOR_W-1:0];
        REG_TRANSPARENT:  cfg.transparent  <= cfg_data[0];
        REG_ORIGIN_X:     cfg.origin_x     <= cfg_data[ORIGIN_W-1:0];
        REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data[ORIGIN_W-1:0];
        REG_FRAME_STRIDE: cfg.frame_stride <= cfg_data[STRIDE_W-1:0];
        REG_ICON_WIDTH:   cfg.icon_width   <= cfg_data[DIM_W-1:0];
        REG_ICON_HEIGHT:  cfg.icon_height  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/mbce_addr.sv
// ----------------------------------------------------------------------------
// mbce_addr
// Input register, row and byte counters, and base address multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_addr
  import mbce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] bitmap_byte,
  output logic                   item_valid,
  input  wire logic              item_take,
  output item_t                  item
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic [SUM_W-1:0]  s1_row_sum;
  logic [SUM_W-1:0]  s1_col_off;
  logic              s1_last;

  logic [ROW_W-1:0]  row_count;
  logic [ROW_W-1:0]  row_count_next;
  logic [COL_W-1:0]  byte_column;
  logic [COL_W-1:0]  byte_column_next;

  logic [BPR_W-1:0]  bytes_per_row;
  logic              row_end;
  logic              icon_end;
  logic              s1_adv;
  logic              s2_adv;
  logic              in_acc;

  assign s2_adv   = !item_valid || item_take;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  always_comb begin
    bytes_per_row = BPR_W'(({1'b0, cfg.icon_width} + 9'd7) >> 3);
    row_end  = ({1'b0, byte_column} + 7'd1) >= {1'b0, bytes_per_row};
    icon_end = row_end && (({1'b0, row_count} + 9'd1) >= {1'b0, cfg.icon_height});
    if (icon_end) begin
      row_count_next   = '0;
      byte_column_next = '0;
    end else if (row_end) begin
      row_count_next   = row_count + ROW_W'(1);
      byte_column_next = '0;
    end else begin
      row_count_next   = row_count;
      byte_column_next = byte_column + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      byte_column <= '0;
      s1_valid    <= 1'b0;
      item_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        row_count   <= row_count_next;
        byte_column <= byte_column_next;
      end
      if (s1_adv) begin
        s1_valid <= in_valid;
      end
      if (s2_adv) begin
        item_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte    <= bitmap_byte;
      s1_row_sum <= SUM_W'(cfg.origin_y) + SUM_W'(row_count);
      s1_col_off <= SUM_W'(cfg.origin_x) + SUM_W'({byte_column, 3'b000});
      s1_last    <= icon_end;
    end
    if (s2_adv && s1_valid) begin
      item.bits <= s1_byte;
      item.base <= FULL_W'(cfg.frame_stride) * FULL_W'(s1_row_sum) + FULL_W'(s1_col_off);
      item.last <= s1_last;
    end
  end

endmodule

`default_nettype wire

### rtl/mbce_serial.sv
// ----------------------------------------------------------------------------
// mbce_serial
// Walks the eight bits of one byte and registers one pixel write per cycle while out_stall does not hold the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_serial
  import mbce_pkg::*;
#(
  parameter int ADDR_WIDTH = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  item_valid,
  output logic                       item_take,
  input  wire item_t                 item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_ADDR_W-1:0]      pixel_address,
  output logic [COLOR_W-1:0]         pixel_color,
  output logic                       write_pixel,
  output logic                       out_of_frame,
  output logic                       last_of_byte,
  output logic                       last_of_icon
);

  localparam int CMP_W = (ADDR_WIDTH >= FULL_W) ? ADDR_WIDTH + 1 : FULL_W + 1;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << ADDR_WIDTH;

  logic                 ser_valid;
  item_t                ser;
  logic [BIT_IDX_W-1:0] ser_k;
  logic                 ser_fire;
  logic                 ser_done;

  logic [FULL_W-1:0]    addr;
  logic                 bit_set;
  logic                 oof;
  logic                 wr;

  assign ser_fire  = ser_valid && (!out_valid || !out_stall);
  assign ser_done  = ser_fire && (ser_k == LAST_BIT);
  assign item_take = !ser_valid || ser_done;

  always_comb begin
    addr    = ser.base + FULL_W'(ser_k);
    bit_set = ser.bits[LAST_BIT - ser_k];
    oof     = CMP_W'(addr) >= LIMIT;
    wr      = (bit_set || !cfg.transparent) && !oof;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_k     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (item_take) begin
        ser_valid <= item_valid;
        ser_k     <= '0;
      end else if (ser_fire) begin
        ser_k <= ser_k + BIT_IDX_W'(1);
      end
      if (ser_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item_valid) begin
      ser <= item;
    end
    if (ser_fire) begin
      pixel_address <= addr[PIX_ADDR_W-1:0];
      pixel_color   <= wr ? (bit_set ? cfg.fg_color : cfg.bg_color) : '0;
      write_pixel   <= wr;
      out_of_frame  <= oof;
      last_of_byte  <= ser_k == LAST_BIT;
      last_of_icon  <= (ser_k == LAST_BIT) && ser.last;
    end
  end

  a_icon_ends_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_icon |-> last_of_byte)
    else $error("icon end flagged away from a byte end");

  a_no_write_oof: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(write_pixel && out_of_frame))
    else $error("write issued outside the frame");

  a_skip_zero_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_pixel |-> pixel_color == '0)
    else $error("skipped pixel carries a color");

  a_byte_restart: assert property (@(posedge clk) disable iff (rst)
    ser_done |=> ser_k == '0)
    else $error("bit index did not restart after a byte");

endmodule

`default_nettype wire

### rtl/mono_bitmap_color_expander_top.sv
// A byte's first pixel goes through the input, address, bit-walk and output registers.
// One pixel write per cycle leaves the single output register while out_stall is low;
// the next byte is accepted while the current one drains.
// Reset: rst is synchronous, active high; clears counters and pipeline valids
// and loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// mono_bitmap_color_expander_top
// Expands 1-bit-per-pixel icon bytes into RGB565 frame buffer pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bitmap_color_expander_top
  import mbce_pkg::*;
#(
  parameter int ADDR_WIDTH = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     bitmap_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_ADDR_W-1:0]      pixel_address,
  output logic [COLOR_W-1:0]         pixel_color,
  output logic                       write_pixel,
  output logic                       out_of_frame,
  output logic                       last_of_byte,
  output logic                       last_of_icon
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_take;

  mbce_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbce_addr u_addr (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .bitmap_byte (bitmap_byte),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item        (item)
  );

  mbce_serial #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_serial (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .item          (item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .write_pixel   (write_pixel),
    .out_of_frame  (out_of_frame),
    .last_of_byte  (last_of_byte),
    .last_of_icon  (last_of_icon)
  );

endmodule

`default_nettype wire

### tb/mono_bitmap_color_expander_top_tb.sv
// ----------------------------------------------------------------------------
// mono_bitmap_color_expander_top_tb
// Drives bitmap bytes and register writes into the expander and checks every
// pixel write against an in-bench model of the icon walk. The stimulus is
// directed corner cases first, then random icons with random idling on both
// sides, and a final stream with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bitmap_color_expander_top_tb;
  import mbce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W       = 20;
  localparam int LATENCY      = 3;
  localparam int ITEMS        = 250;
  localparam int FIXED_ITEMS  = 65;
  localparam int RANDOM_ITEMS = ITEMS - FIXED_ITEMS;
  localparam int STUCK_LIMIT  = 1000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIX_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0]    color;
    logic                  wr;
    logic                  oof;
    logic                  byte_end;
    logic                  icon_end;
  } pixel_t;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     bitmap_byte = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [PIX_ADDR_W-1:0] pixel_address;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  write_pixel;
  logic                  out_of_frame;
  logic                  last_of_byte;
  logic                  last_of_icon;

  cfg_t        regs;
  logic [7:0]  row_idx  = '0;
  logic [5:0]  byte_col = '0;
  pixel_t      pending_pixels[$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  bit          steady      = 1'b0;

  mono_bitmap_color_expander_top #(
    .ADDR_WIDTH(ADDR_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .bitmap_byte  (bitmap_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_address(pixel_address),
    .pixel_color  (pixel_color),
    .write_pixel  (write_pixel),
    .out_of_frame (out_of_frame),
    .last_of_byte (last_of_byte),
    .last_of_icon (last_of_icon)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    regs.fg_color     = FG_RESET;
    regs.bg_color     = BG_RESET;
    regs.transparent  = 1'b1;
    regs.origin_x     = '0;
    regs.origin_y     = '0;
    regs.frame_stride = STRIDE_RESET;
    regs.icon_width   = WIDTH_RESET;
    regs.icon_height  = HEIGHT_RESET;
  end

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FG_COLOR:     regs.fg_color     = data[COLOR_W-1:0];
      REG_BG_COLOR:     regs.bg_color     = data[COLOR_W-1:0];
      REG_TRANSPARENT:  regs.transparent  = data[0];
      REG_ORIGIN_X:     regs.origin_x     = data[ORIGIN_W-1:0];
      REG_ORIGIN_Y:     regs.origin_y     = data[ORIGIN_W-1:0];
      REG_FRAME_STRIDE: regs.frame_stride = data[STRIDE_W-1:0];
      REG_ICON_WIDTH:   regs.icon_width   = data[DIM_W-1:0];
      REG_ICON_HEIGHT:  regs.icon_height  = data[DIM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void expand_byte(input logic [BYTE_W-1:0] bits);
    logic [31:0] width, height, stride, ox, oy, row, col, bpr, base, addr;
    logic        row_end, icon_end, bit_set, oof, wr;
    pixel_t      p;
    width    = regs.icon_width;
    height   = regs.icon_height;
    stride   = regs.frame_stride;
    ox       = regs.origin_x;
    oy       = regs.origin_y;
    row      = row_idx;
    col      = byte_col;
    bpr      = (width + 32'd7) / 32'd8;
    row_end  = (col + 32'd1) >= bpr;
    icon_end = row_end && ((row + 32'd1) >= height);
    base     = stride * (oy + row) + ox + col * 32'd8;
    for (int k = 0; k < 8; k++) begin
      addr       = base + 32'(k);
      bit_set    = bits[7 - k];
      oof        = addr >= (32'd1 << ADDR_W);
      wr         = (bit_set || !regs.transparent) && !oof;
      p.addr     = addr[PIX_ADDR_W-1:0];
      p.color    = wr ? (bit_set ? regs.fg_color : regs.bg_color) : '0;
      p.wr       = wr;
      p.oof      = oof;
      p.byte_end = (k == 7);
      p.icon_end = (k == 7) && icon_end;
      pending_pixels.push_back(p);
    end
    if (icon_end) begin
      row_idx  = '0;
      byte_col = '0;
    end else if (row_end) begin
      row_idx  = row_idx + 8'd1;
      byte_col = '0;
    end else begin
      byte_col = byte_col + 6'd1;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                      input int w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
    return (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
  endfunction

  // receiver: random stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pixel_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{pixel_address, pixel_color, write_pixel, out_of_frame,
               last_of_byte, last_of_icon};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected pixel addr=%h color=%h wr=%b oof=%b lob=%b loi=%b",
                   $realtime, seen.addr, seen.color, seen.wr, seen.oof,
                   seen.byte_end, seen.icon_end);
      end else begin
        want = pending_pixels.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"%0t: pixel mismatch exp addr=%h color=%h wr=%b oof=%b lob=%b ",
                      "loi=%b, got addr=%h color=%h wr=%b oof=%b lob=%b loi=%b"},
                     $realtime, want.addr, want.color, want.wr, want.oof,
                     want.byte_end, want.icon_end, seen.addr, seen.color, seen.wr,
                     seen.oof, seen.byte_end, seen.icon_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    bitmap_byte <= b;
    do @(posedge clk); while (in_stall);
    expand_byte(b);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic settle_block();
    hold_until_drained();
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h00);
  endtask

  task automatic test_colors();
    settle_block();
    write_reg(REG_TRANSPARENT, 16'hFFFE);
    write_reg(REG_FG_COLOR, 16'h0000);
    write_reg(REG_BG_COLOR, 16'hFFFF);
    send_byte(8'hF0);
    send_byte(8'h0F);
    settle_block();
    write_reg(REG_FG_COLOR, 16'hFFFF);
    write_reg(REG_BG_COLOR, 16'h0000);
    write_reg(REG_TRANSPARENT, 16'h0001);
    send_byte(8'hAA);
  endtask

  task automatic test_frame_limits();
    settle_block();
    write_reg(REG_TRANSPARENT, 16'h0000);
    write_reg(REG_ORIGIN_X, 16'hFFFF);
    write_reg(REG_ORIGIN_Y, 16'h03FF);
    write_reg(REG_FRAME_STRIDE, 16'hFFFF);
    write_reg(REG_ICON_WIDTH, 16'h00FF);
    write_reg(REG_ICON_HEIGHT, 16'hFFFF);
    write_reg(8'hFF, 16'h1234);
    write_reg(8'h08, 16'hFFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h3C);
    send_byte(8'hC3);
    // straddle the top of the address space
    settle_block();
    write_reg(REG_FRAME_STRIDE, 16'd1024);
    write_reg(REG_ORIGIN_X, 16'd1020);
    write_reg(REG_ICON_WIDTH, 16'd8);
    write_reg(REG_ICON_HEIGHT, 16'd1);
    send_byte(8'h5A);
  endtask

  task automatic test_zero_geometry();
    settle_block();
    write_reg(REG_FRAME_STRIDE, 16'd0);
    write_reg(REG_ORIGIN_X, 16'd5);
    write_reg(REG_ORIGIN_Y, 16'd7);
    write_reg(REG_ICON_WIDTH, 16'hFF00);
    write_reg(REG_ICON_HEIGHT, 16'd0);
    send_byte(8'h81);
    send_byte(8'h7E);
    send_byte(8'h00);
    settle_block();
    write_reg(REG_FRAME_STRIDE, 16'd1);
    write_reg(REG_ICON_WIDTH, 16'd1);
    write_reg(REG_ICON_HEIGHT, 16'd1);
    send_byte(8'hFF);
  endtask

  task automatic test_counter_overrun();
    settle_block();
    write_reg(REG_ORIGIN_X, 16'd0);
    write_reg(REG_ORIGIN_Y, 16'd0);
    write_reg(REG_FRAME_STRIDE, 16'd64);
    write_reg(REG_ICON_WIDTH, 16'd32);
    write_reg(REG_ICON_HEIGHT, 16'd4);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h44);
    // shrink the row under a live column
    settle_block();
    write_reg(REG_ICON_WIDTH, 16'd8);
    send_byte(8'h88);
    send_byte(8'h99);
    // shrink the icon under a live row
    settle_block();
    write_reg(REG_ICON_HEIGHT, 16'd2);
    send_byte(8'hE7);
    send_byte(8'h18);
    send_byte(8'hFF);
  endtask

  task automatic test_random_icons();
    int  sent, pause_at, icons, total, w, h, s;
    bit  big;
    logic [BYTE_W-1:0] b;
    sent     = 0;
    pause_at = $urandom_range(40, 150);
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      big = ($urandom_range(0, 5) == 0);
      w   = big ? $urandom_range(1, 255) : $urandom_range(1, 40);
      h   = big ? $urandom_range(1, 255) : $urandom_range(1, 4);
      case ($urandom_range(0, 7))
        0:       s = 0;
        1:       s = 2047;
        2:       s = 1024;
        3:       s = 1;
        default: s = $urandom_range(1, 1024);
      endcase
      write_reg(REG_FG_COLOR, 16'($urandom));
      write_reg(REG_BG_COLOR, 16'($urandom));
      write_reg(REG_TRANSPARENT, with_junk(16'($urandom_range(0, 1)), 1));
      write_reg(REG_ORIGIN_X, with_junk(16'($urandom_range(0, 1023)), ORIGIN_W));
      write_reg(REG_ORIGIN_Y, with_junk(16'($urandom_range(0, 1023)), ORIGIN_W));
      write_reg(REG_FRAME_STRIDE, with_junk(16'(s), STRIDE_W));
      write_reg(REG_ICON_WIDTH, with_junk(16'(w), DIM_W));
      write_reg(REG_ICON_HEIGHT, with_junk(16'(h), DIM_W));
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_IDX_W'($urandom_range(8, 255)), 16'($urandom));
      icons = $urandom_range(1, 3);
      repeat (icons) begin
        total = ((w + 7) / 8) * h;
        if (total > 48) total = 48;
        if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
        if (total > RANDOM_ITEMS - sent) total = RANDOM_ITEMS - sent;
        repeat (total) begin
          case ($urandom_range(0, 3))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = BYTE_W'($urandom);
          endcase
          send_byte(b);
          sent++;
          if (sent == pause_at) hold_until_drained();
        end
      end
    end
  endtask

  task automatic test_steady_stream();
    settle_block();
    steady = 1'b1;
    write_reg(REG_TRANSPARENT, 16'd0);
    write_reg(REG_ORIGIN_X, 16'd100);
    write_reg(REG_ORIGIN_Y, 16'd50);
    write_reg(REG_FRAME_STRIDE, 16'd640);
    write_reg(REG_ICON_WIDTH, 16'd16);
    write_reg(REG_ICON_HEIGHT, 16'd3);
    repeat (42) send_byte(BYTE_W'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_colors();
    test_frame_limits();
    test_zero_geometry();
    test_counter_overrun();
    test_random_icons();
    test_steady_stream();
    hold_until_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/mbce_pkg.sv
rtl/mbce_cfg.sv
rtl/mbce_addr.sv
rtl/mbce_serial.sv
rtl/mono_bitmap_color_expander_top.sv
tb/mono_bitmap_color_expander_top_tb.sv
